/* rtl/dual_stack_shared_buffer_core_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the dual stack shared buffer core
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_BUFFER_CORE_MACROS_SVH
`define DUAL_STACK_SHARED_BUFFER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsb assertion failed: same-cycle check");

// next-cycle implication, checked out of reset
`define DSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsb assertion failed: next-cycle check");

`endif

/* rtl/dsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_pkg
// shared constants, codes and types of the dual stack shared buffer
// ----------------------------------------------------------------------------
package dsb_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WORD_W    = 32;

   localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

   // operation kinds
   localparam logic [1:0] KIND_PUSH_ONE = 2'd0;
   localparam logic [1:0] KIND_PUSH_TWO = 2'd1;
   localparam logic [1:0] KIND_POP_ONE  = 2'd2;
   localparam logic [1:0] KIND_POP_TWO  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_RESULT = 2'b10
   } state_type;

   // decoded operation, only the flag of a performed operation is set
   typedef struct packed {
      logic       push_one;
      logic       push_two;
      logic       pop_one;
      logic       pop_two;
      logic [1:0] status;
   } op_info_type;

endpackage

/* rtl/dual_stack_shared_buffer_core.sv */
`timescale 1ns / 1ps
// a word's operation is registered when the word is taken; its result is loaded into the output
//    register in the result state once that register is free, and no new word is taken before
//    that load, since the single-port store returns the read data of a pop from a register
// a finished result waits in the output register while the next word is taken
// reset: synchronous, clears both stack counts, the sequencer and the output valid;
//    the store itself is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_core
// two stacks growing toward each other in one shared word store
// ----------------------------------------------------------------------------
`include "dual_stack_shared_buffer_core_macros.svh"

module dual_stack_shared_buffer_core #(
   parameter int DEPTH = dsb_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic signed [dsb_pkg::WORD_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic signed [dsb_pkg::WORD_W-1:0] rsp_top_one,
   output logic signed [dsb_pkg::WORD_W-1:0] rsp_top_two,
   output logic                             rsp_empty_one,
   output logic                             rsp_empty_two
);

   localparam int ADDR_W = $clog2(DEPTH);

   dsb_pkg::state_type   state_ff, state_in;
   dsb_pkg::op_info_type info;
   dsb_pkg::op_info_type op_ff;

   logic [dsb_pkg::WORD_W-1:0] value_ff;
   logic [dsb_pkg::WORD_W-1:0] top_one_ff, top_one_in;
   logic [dsb_pkg::WORD_W-1:0] top_two_ff, top_two_in;
   logic [dsb_pkg::WORD_W-1:0] rd_data;
   logic [ADDR_W-1:0]          mem_addr;
   logic                       mem_we, mem_re;
   logic                       empty_one, empty_two;
   logic                       accept, out_load;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff;
   logic [dsb_pkg::WORD_W-1:0] rsp_top_one_ff, rsp_top_two_ff;
   logic                       rsp_empty_one_ff, rsp_empty_two_ff;

   // one word in flight at a time, so a pop never reads an entry written in the same cycle
   assign req_stall = (state_ff != dsb_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == dsb_pkg::ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   dsb_ptrs #(
      .DEPTH (DEPTH)
   ) u_ptrs (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .info      (info),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .empty_one (empty_one),
      .empty_two (empty_two)
   );

   dsb_mem #(
      .DEPTH (DEPTH),
      .WIDTH (dsb_pkg::WORD_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (req_value),
      .rdata (rd_data)
   );

   // counts are already updated here, so the empty flags are post-step
   always_comb begin
      top_one_in = top_one_ff;
      top_two_in = top_two_ff;
      if (empty_one) begin
         top_one_in = dsb_pkg::EMPTY_WORD;
      end else if (op_ff.pop_one) begin
         top_one_in = rd_data;
      end else if (op_ff.push_one) begin
         top_one_in = value_ff;
      end
      if (empty_two) begin
         top_two_in = dsb_pkg::EMPTY_WORD;
      end else if (op_ff.pop_two) begin
         top_two_in = rd_data;
      end else if (op_ff.push_two) begin
         top_two_in = value_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = dsb_pkg::ST_RESULT;
            end
         end
         dsb_pkg::ST_RESULT: begin
            if (out_load) begin
               state_in = dsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dsb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= info;
         value_ff <= req_value;
      end
      if (out_load) begin
         top_one_ff       <= top_one_in;
         top_two_ff       <= top_two_in;
         rsp_status_ff    <= op_ff.status;
         rsp_top_one_ff   <= top_one_in;
         rsp_top_two_ff   <= top_two_in;
         rsp_empty_one_ff <= empty_one;
         rsp_empty_two_ff <= empty_two;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_top_one   = rsp_top_one_ff;
   assign rsp_top_two   = rsp_top_two_ff;
   assign rsp_empty_one = rsp_empty_one_ff;
   assign rsp_empty_two = rsp_empty_two_ff;

   `DSB_ASSERT_NEXT(a_accept_to_result, clock, reset, accept, state_ff == dsb_pkg::ST_RESULT)
   `DSB_ASSERT_NOW(a_empty_one_word, clock, reset, rsp_valid_ff && rsp_empty_one_ff,
      rsp_top_one_ff == dsb_pkg::EMPTY_WORD)
   `DSB_ASSERT_NOW(a_empty_two_word, clock, reset, rsp_valid_ff && rsp_empty_two_ff,
      rsp_top_two_ff == dsb_pkg::EMPTY_WORD)

endmodule

/* rtl/dsb_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_mem
// single-port synchronous word store with registered read data
// ----------------------------------------------------------------------------
module dsb_mem #(
   parameter  int DEPTH  = dsb_pkg::DEPTH_DEF,
   parameter  int WIDTH  = dsb_pkg::WORD_W,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/dsb_ptrs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsb_ptrs
// stack counts, full and empty checks, and store address generation
// ----------------------------------------------------------------------------
`include "dual_stack_shared_buffer_core_macros.svh"

module dsb_ptrs #(
   parameter  int DEPTH  = dsb_pkg::DEPTH_DEF,
   localparam int CNT_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          kind,
   output dsb_pkg::op_info_type info,
   output logic                mem_we,
   output logic                mem_re,
   output logic [ADDR_W-1:0]   mem_addr,
   output logic                empty_one,
   output logic                empty_two
);

   logic [CNT_W-1:0] count_one_ff, count_one_in;
   logic [CNT_W-1:0] count_two_ff, count_two_in;
   logic [CNT_W:0]   count_sum;
   logic             full;
   logic             refused;

   assign count_sum = {1'b0, count_one_ff} + {1'b0, count_two_ff};
   assign full      = (count_sum == (CNT_W + 1)'(DEPTH));
   assign empty_one = (count_one_ff == '0);
   assign empty_two = (count_two_ff == '0);
   assign refused   = accept && (info.status != dsb_pkg::STATUS_DONE);

   always_comb begin
      info         = '0;
      info.status  = dsb_pkg::STATUS_DONE;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      case (kind)
         dsb_pkg::KIND_PUSH_ONE: begin
            if (full) begin
               info.status = dsb_pkg::STATUS_OVERFLOW;
            end else begin
               info.push_one = 1'b1;
               mem_we        = accept;
               mem_addr      = count_one_ff[ADDR_W-1:0];
               count_one_in  = count_one_ff + CNT_W'(1);
            end
         end
         dsb_pkg::KIND_PUSH_TWO: begin
            if (full) begin
               info.status = dsb_pkg::STATUS_OVERFLOW;
            end else begin
               info.push_two = 1'b1;
               mem_we        = accept;
               mem_addr      = ADDR_W'(CNT_W'(DEPTH - 1) - count_two_ff);
               count_two_in  = count_two_ff + CNT_W'(1);
            end
         end
         dsb_pkg::KIND_POP_ONE: begin
            if (empty_one) begin
               info.status = dsb_pkg::STATUS_UNDERFLOW;
            end else begin
               // fetch the word under the popped one, unused if the stack drains
               info.pop_one = 1'b1;
               mem_re       = accept;
               mem_addr     = ADDR_W'(count_one_ff - CNT_W'(2));
               count_one_in = count_one_ff - CNT_W'(1);
            end
         end
         default: begin
            if (empty_two) begin
               info.status = dsb_pkg::STATUS_UNDERFLOW;
            end else begin
               info.pop_two = 1'b1;
               mem_re       = accept;
               mem_addr     = ADDR_W'(CNT_W'(DEPTH) - count_two_ff + CNT_W'(1));
               count_two_in = count_two_ff - CNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_one_ff <= '0;
         count_two_ff <= '0;
      end else if (accept) begin
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
      end
   end

   `DSB_ASSERT_NOW(a_counts_fit, clock, reset, 1'b1, count_sum <= (CNT_W + 1)'(DEPTH))
   `DSB_ASSERT_NEXT(a_refused_holds, clock, reset, refused, $stable(count_one_ff))
   `DSB_ASSERT_NOW(a_one_access, clock, reset, 1'b1, !(mem_we && mem_re))

endmodule

/* dv/dual_stack_shared_buffer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_core_tb
// self-checking bench for the two stacks that share one word store
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_core_tb;

   localparam int STORE_DEPTH  = dsb_pkg::DEPTH_DEF;
   localparam int IDX_W        = $clog2(STORE_DEPTH);
   localparam int DATA_W       = dsb_pkg::WORD_W;
   localparam int RANDOM_WORDS = 1200;
   localparam int HOLD_CYCLES  = 300;
   localparam int TABLE_ROWS   = 14;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] top_one;
      logic [DATA_W-1:0] top_two;
      logic              empty_one;
      logic              empty_two;
   } stack_result_type;

   typedef struct {
      logic [1:0]        kind;
      logic [DATA_W-1:0] word;
      int                reps;
      bit                typed;
      stack_result_type  want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_kind;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_top_one;
   logic signed [DATA_W-1:0] rsp_top_two;
   logic                     rsp_empty_one;
   logic                     rsp_empty_two;

   // behavioral copy of the stacks
   logic [DATA_W-1:0] mirror_store [0:STORE_DEPTH-1];
   int                mirror_count_one;
   int                mirror_count_two;

   stack_result_type  pending_results [$];
   stim_row_type      stim_table [0:TABLE_ROWS-1];
   int                mismatch_count = 0;
   bit                calm = 1'b0;
   bit                hold_off_req = 1'b0;

   dual_stack_shared_buffer_core #(
      .DEPTH(STORE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_top_one   (rsp_top_one),
      .rsp_top_two   (rsp_top_two),
      .rsp_empty_one (rsp_empty_one),
      .rsp_empty_two (rsp_empty_two)
   );

   always #2 clock = ~clock;

   function automatic stack_result_type apply_stack_op(input logic [1:0] kind,
                                                       input logic [DATA_W-1:0] word);
      stack_result_type res;
      bit               full;
      full       = (mirror_count_one + mirror_count_two) >= STORE_DEPTH;
      res.status = dsb_pkg::STATUS_DONE;
      case (kind)
         dsb_pkg::KIND_PUSH_ONE: begin
            if (full) begin
               res.status = dsb_pkg::STATUS_OVERFLOW;
            end else begin
               mirror_store[IDX_W'(mirror_count_one)] = word;
               mirror_count_one++;
            end
         end
         dsb_pkg::KIND_PUSH_TWO: begin
            if (full) begin
               res.status = dsb_pkg::STATUS_OVERFLOW;
            end else begin
               mirror_count_two++;
               mirror_store[IDX_W'(STORE_DEPTH - mirror_count_two)] = word;
            end
         end
         dsb_pkg::KIND_POP_ONE: begin
            if (mirror_count_one == 0) res.status = dsb_pkg::STATUS_UNDERFLOW;
            else mirror_count_one--;
         end
         default: begin
            if (mirror_count_two == 0) res.status = dsb_pkg::STATUS_UNDERFLOW;
            else mirror_count_two--;
         end
      endcase
      res.top_one   = (mirror_count_one == 0) ? dsb_pkg::EMPTY_WORD
                    : mirror_store[IDX_W'(mirror_count_one - 1)];
      res.top_two   = (mirror_count_two == 0) ? dsb_pkg::EMPTY_WORD
                    : mirror_store[IDX_W'(STORE_DEPTH - mirror_count_two)];
      res.empty_one = (mirror_count_one == 0);
      res.empty_two = (mirror_count_two == 0);
      return res;
   endfunction

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic send_word(input logic [1:0] kind, input logic [DATA_W-1:0] word,
                            input bit typed, input stack_result_type want);
      stack_result_type predicted;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_stack_op(kind, word);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic idle_sender();
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: checks each accepted word and drives the stall
   initial begin
      stack_result_type want;
      int               stall_left;
      int               hold_left;
      int               len;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall <= 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual status %h",
                        $time, rsp_status);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
               check_field("top_one", want.top_one, rsp_top_one);
               check_field("top_two", want.top_two, rsp_top_two);
               check_field("empty_one", DATA_W'(want.empty_one), DATA_W'(rsp_empty_one));
               check_field("empty_two", DATA_W'(want.empty_two), DATA_W'(rsp_empty_two));
            end
         end
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            len = calm ? 0 : pick_gap();
            if (len > 0) begin
               rsp_stall  <= 1'b1;
               stall_left  = len - 1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // stimulus
   initial begin
      stack_result_type  none;
      logic [1:0]        kind;
      logic [DATA_W-1:0] word;
      int                push_pct;
      int                burst_len;
      int                burst_no;
      int                random_sent;
      none        = '0;
      burst_no    = 0;
      random_sent = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_kind  <= dsb_pkg::KIND_PUSH_ONE;
      req_value <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) mirror_store[IDX_W'(i)] = '0;
      mirror_count_one = 0;
      mirror_count_two = 0;

      // pops on an empty buffer, extremes, a stored -1 against an empty stack
      stim_table[0]  = '{dsb_pkg::KIND_POP_ONE, 32'h0, 1, 1'b1,
                         '{dsb_pkg::STATUS_UNDERFLOW, dsb_pkg::EMPTY_WORD,
                           dsb_pkg::EMPTY_WORD, 1'b1, 1'b1}};
      stim_table[1]  = '{dsb_pkg::KIND_POP_TWO, 32'hFFFF_FFFF, 1, 1'b1,
                         '{dsb_pkg::STATUS_UNDERFLOW, dsb_pkg::EMPTY_WORD,
                           dsb_pkg::EMPTY_WORD, 1'b1, 1'b1}};
      stim_table[2]  = '{dsb_pkg::KIND_PUSH_ONE, 32'h7FFF_FFFF, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'h7FFF_FFFF, dsb_pkg::EMPTY_WORD,
                           1'b0, 1'b1}};
      stim_table[3]  = '{dsb_pkg::KIND_PUSH_TWO, 32'h8000_0000, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0}};
      stim_table[4]  = '{dsb_pkg::KIND_PUSH_ONE, 32'hFFFF_FFFF, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0}};
      stim_table[5]  = '{dsb_pkg::KIND_PUSH_TWO, 32'h0, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0}};
      stim_table[6]  = '{dsb_pkg::KIND_POP_ONE, 32'h5555_AAAA, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0}};
      stim_table[7]  = '{dsb_pkg::KIND_POP_ONE, 32'h0, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, dsb_pkg::EMPTY_WORD, 32'h0, 1'b1, 1'b0}};
      // fill the buffer, then push into it from both ends
      stim_table[8]  = '{dsb_pkg::KIND_PUSH_ONE, 32'hA5A5_A5A5, 13, 1'b0, none};
      stim_table[9]  = '{dsb_pkg::KIND_PUSH_ONE, 32'h1234_5678, 1, 1'b1,
                         '{dsb_pkg::STATUS_DONE, 32'h1234_5678, 32'h0, 1'b0, 1'b0}};
      stim_table[10] = '{dsb_pkg::KIND_PUSH_ONE, 32'h1, 1, 1'b1,
                         '{dsb_pkg::STATUS_OVERFLOW, 32'h1234_5678, 32'h0, 1'b0, 1'b0}};
      stim_table[11] = '{dsb_pkg::KIND_PUSH_TWO, 32'h2, 1, 1'b1,
                         '{dsb_pkg::STATUS_OVERFLOW, 32'h1234_5678, 32'h0, 1'b0, 1'b0}};
      // drain stack two so the next pop underflows with stack one untouched
      stim_table[12] = '{dsb_pkg::KIND_POP_TWO, 32'h3C3C_C3C3, 2, 1'b0, none};
      stim_table[13] = '{dsb_pkg::KIND_POP_TWO, 32'h0, 1, 1'b1,
                         '{dsb_pkg::STATUS_UNDERFLOW, 32'h1234_5678, dsb_pkg::EMPTY_WORD,
                           1'b0, 1'b1}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_ROWS; i++) begin
         repeat (stim_table[i].reps) begin
            send_word(stim_table[i].kind, stim_table[i].word, stim_table[i].typed,
                      stim_table[i].want);
            idle_sender();
         end
      end

      // random bursts, each with its own lean toward pushes or pops
      while (random_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 2))
            0: push_pct = 15;
            1: push_pct = 50;
            default: push_pct = 85;
         endcase
         calm      = ($urandom_range(0, 3) == 0);
         burst_len = $urandom_range(20, 60);
         burst_no++;
         if (burst_no == 4) hold_off_req = 1'b1;
         if (burst_no == 9) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         repeat (burst_len) begin
            if ($urandom_range(0, 99) < push_pct)
               kind = $urandom_range(0, 1) ? dsb_pkg::KIND_PUSH_TWO : dsb_pkg::KIND_PUSH_ONE;
            else
               kind = $urandom_range(0, 1) ? dsb_pkg::KIND_POP_TWO : dsb_pkg::KIND_POP_ONE;
            case ($urandom_range(0, 15))
               0: word = 32'h7FFF_FFFF;
               1: word = 32'h8000_0000;
               2: word = 32'hFFFF_FFFF;
               3: word = 32'h0;
               default: word = $urandom();
            endcase
            send_word(kind, word, 1'b0, none);
            random_sent++;
            idle_sender();
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("dual_stack_shared_buffer_core regression: pass");
      end else begin
         $display("dual_stack_shared_buffer_core regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("dual_stack_shared_buffer_core regression: fail");
      $finish;
   end

endmodule

/* dual_stack_shared_buffer_core.f */
+incdir+rtl
rtl/dsb_pkg.sv
rtl/dsb_mem.sv
rtl/dsb_ptrs.sv
rtl/dual_stack_shared_buffer_core.sv
dv/dual_stack_shared_buffer_core_tb.sv
